@@ rtl/core/oriented_box_aabb_assert.svh @@
// Assertion macros for the oriented box bounds block
`ifndef ORIENTED_BOX_AABB_ASSERT_SVH
`define ORIENTED_BOX_AABB_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define OBA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("oriented_box_aabb: same-cycle check failed");

// Check that a condition implies another in the next cycle
`define OBA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("oriented_box_aabb: next-cycle check failed");

`endif

@@ rtl/core/obaabb_pkg.sv @@
// Shared types, constants and arithmetic helpers for the oriented box bounds block
package obaabb_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int ANGLE_BITS = 16;
	localparam int QFRAC      = 30;
	localparam int AIW        = 16;
	localparam int AQW        = ANGLE_BITS - 2;
	localparam int QW         = 34;
	localparam int UW         = QFRAC + 1;
	localparam int RW         = 32;
	localparam int SW         = 31;
	localparam int VW         = 32;
	localparam int CW         = VW + 1;
	localparam int HW         = SW + VW - (FRAC_BITS + 1);
	localparam int HHW        = HW - QFRAC;
	localparam int TW         = HHW + RW;
	localparam int EW         = TW + 2;
	localparam int BW         = EW + 2;
	localparam int NCOEF      = 7;
	localparam int NST        = 14;

	localparam logic [SW-1:0] SIZE_MIN   = SW'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [SW-1:0] SIZE_RESET = SW'(64'd1 << FRAC_BITS);
	localparam logic signed [QW-1:0] QONE = QW'(64'd1 << QFRAC);

	localparam logic signed [QW-1:0] SIN_COEF [NCOEF] = '{
		34'sd1686629713, -34'sd693598668, 34'sd85569306, -34'sd5026995,
		34'sd172272, -34'sd3864, 34'sd61
	};

	typedef enum logic [2:0] {
		REG_SIZE_X = 3'd0,
		REG_SIZE_Y = 3'd1,
		REG_SIZE_Z = 3'd2,
		REG_OFF_X  = 3'd3,
		REG_OFF_Y  = 3'd4,
		REG_OFF_Z  = 3'd5
	} reg_idx_t;

	// One polynomial lane: running value, u squared and u
	typedef struct packed {
		logic [QW-1:0] p;
		logic [UW-1:0] u2;
		logic [UW-1:0] u;
	} lane_t;

	// Two lanes per axis: even lane evaluates S(f), odd lane S(1 - f)
	typedef lane_t [5:0] lvec_t;

	// Data that travels beside the sine evaluation
	typedef struct packed {
		logic [2:0][CW-1:0] centre;
		logic [2:0][HW-1:0] h;
		logic [2:0][1:0]    quad;
		logic [2:0]         fz;
	} side_t;

	typedef logic [8:0][RW-1:0] rm_t;

	// Q30 product, truncated toward zero
	function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
		input logic signed [QW-1:0] b);
		logic [QW-1:0]   ma;
		logic [QW-1:0]   mb;
		logic [2*QW-1:0] pr;
		logic [QW-1:0]   m;
		ma = a[QW-1] ? QW'(-a) : QW'(a);
		mb = b[QW-1] ? QW'(-b) : QW'(b);
		pr = ma * mb;
		m  = pr[QFRAC +: QW];
		qmul = (a[QW-1] ^ b[QW-1]) ? -$signed(m) : $signed(m);
	endfunction

	// Magnitude of a Q30 value
	function automatic logic [RW-1:0] qmag(input logic signed [QW-1:0] a);
		qmag = a[QW-1] ? RW'(-a) : RW'(a);
	endfunction

	// Clamp a wide bound into the signed 32-bit range
	function automatic logic [VW-1:0] sat32(input logic signed [BW-1:0] v);
		logic signed [BW-1:0] vmax;
		logic signed [BW-1:0] vmin;
		vmax = BW'((64'sd1 <<< (VW - 1)) - 64'sd1);
		vmin = -(BW'(64'sd1 <<< (VW - 1)));
		if (v > vmax)
			sat32 = vmax[VW-1:0];
		else if (v < vmin)
			sat32 = vmin[VW-1:0];
		else
			sat32 = v[VW-1:0];
	endfunction

endpackage

@@ rtl/core/obaabb_horner_cell.sv @@
// One Horner step of the quarter-sine polynomial across all six lanes
module obaabb_horner_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic signed [obaabb_pkg::QW-1:0] coef,
	input  logic                           vld_i,
	input  obaabb_pkg::lvec_t              lanes_i,
	input  obaabb_pkg::side_t              side_i,
	output logic                           vld_o,
	output obaabb_pkg::lvec_t              lanes_o,
	output obaabb_pkg::side_t              side_o
);
	import obaabb_pkg::*;

	lvec_t lanes_d;

	// Multiply by u squared and add the next coefficient
	always_comb begin
		for (int l = 0; l < 6; l++) begin
			lanes_d[l].p  = QW'(coef + qmul($signed(lanes_i[l].p), $signed(QW'(lanes_i[l].u2))));
			lanes_d[l].u2 = lanes_i[l].u2;
			lanes_d[l].u  = lanes_i[l].u;
		end
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o <= 1'b0;
		else if (en)
			vld_o <= vld_i;
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			lanes_o <= lanes_d;
			side_o  <= side_i;
		end
	end

endmodule

@@ rtl/core/obaabb_matrix.sv @@
// Sine/cosine finish and rotation matrix magnitudes, three stages
module obaabb_matrix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [2:0]        en,
	input  logic              vld_i,
	input  obaabb_pkg::lvec_t lanes_i,
	input  obaabb_pkg::side_t side_i,
	output logic [2:0]        vld_o,
	output obaabb_pkg::rm_t   rm_o,
	output obaabb_pkg::side_t side_o
);
	import obaabb_pkg::*;

	logic signed [QW-1:0] s_d [3];
	logic signed [QW-1:0] c_d [3];
	logic [2:0][QW-1:0]   s_s1;
	logic [2:0][QW-1:0]   c_s1;
	side_t                side_s1;
	side_t                side_s2;

	logic signed [QW-1:0] sxsy_s2, cxsy_s2, cycz_s2, cysz_s2, sy_s2, cxsz_s2;
	logic signed [QW-1:0] cxcz_s2, sxcy_s2, sxsz_s2, cxcy_s2, sxcz_s2, cz_s2, sz_s2;
	rm_t                  rm_d;

	// Finish the polynomial, clamp and fold quadrants
	always_comb begin
		logic signed [QW-1:0] ps;
		logic signed [QW-1:0] pc;
		logic signed [QW-1:0] s0;
		logic signed [QW-1:0] c0;
		for (int a = 0; a < 3; a++) begin
			ps = qmul($signed(lanes_i[2*a].p), $signed(QW'(lanes_i[2*a].u)));
			pc = qmul($signed(lanes_i[2*a+1].p), $signed(QW'(lanes_i[2*a+1].u)));
			if (ps < 0) ps = '0;
			if (ps > QONE) ps = QONE;
			if (pc < 0) pc = '0;
			if (pc > QONE) pc = QONE;
			s0 = side_i.fz[a] ? '0 : ps;
			c0 = side_i.fz[a] ? QONE : pc;
			unique case (side_i.quad[a])
				2'd0: begin s_d[a] = s0;  c_d[a] = c0;  end
				2'd1: begin s_d[a] = c0;  c_d[a] = -s0; end
				2'd2: begin s_d[a] = -s0; c_d[a] = -c0; end
				default: begin s_d[a] = -c0; c_d[a] = s0; end
			endcase
		end
	end

	// Second-level matrix products, sums and magnitudes
	always_comb begin
		rm_d[0] = qmag(cycz_s2);
		rm_d[1] = qmag(cysz_s2);
		rm_d[2] = qmag(sy_s2);
		rm_d[3] = qmag(QW'(qmul(sxsy_s2, cz_s2) + cxsz_s2));
		rm_d[4] = qmag(QW'(cxcz_s2 - qmul(sxsy_s2, sz_s2)));
		rm_d[5] = qmag(sxcy_s2);
		rm_d[6] = qmag(QW'(sxsz_s2 - qmul(cxsy_s2, cz_s2)));
		rm_d[7] = qmag(QW'(qmul(cxsy_s2, sz_s2) + sxcz_s2));
		rm_d[8] = qmag(cxcy_s2);
	end

	// Advance valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= '0;
		end else begin
			if (en[0]) vld_o[0] <= vld_i;
			if (en[1]) vld_o[1] <= vld_o[0];
			if (en[2]) vld_o[2] <= vld_o[1];
		end
	end

	// Hold sine and cosine per axis
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int a = 0; a < 3; a++) begin
				s_s1[a] <= s_d[a];
				c_s1[a] <= c_d[a];
			end
			side_s1 <= side_i;
		end
	end

	// First-level products of sines and cosines
	always_ff @(posedge clk) begin
		if (en[1]) begin
			sxsy_s2 <= qmul($signed(s_s1[0]), $signed(s_s1[1]));
			cxsy_s2 <= qmul($signed(c_s1[0]), $signed(s_s1[1]));
			cycz_s2 <= qmul($signed(c_s1[1]), $signed(c_s1[2]));
			cysz_s2 <= qmul($signed(c_s1[1]), $signed(s_s1[2]));
			sy_s2   <= $signed(s_s1[1]);
			cxsz_s2 <= qmul($signed(c_s1[0]), $signed(s_s1[2]));
			cxcz_s2 <= qmul($signed(c_s1[0]), $signed(c_s1[2]));
			sxcy_s2 <= qmul($signed(s_s1[0]), $signed(c_s1[1]));
			sxsz_s2 <= qmul($signed(s_s1[0]), $signed(s_s1[2]));
			cxcy_s2 <= qmul($signed(c_s1[0]), $signed(c_s1[1]));
			sxcz_s2 <= qmul($signed(s_s1[0]), $signed(c_s1[2]));
			cz_s2   <= $signed(c_s1[2]);
			sz_s2   <= $signed(s_s1[2]);
			side_s2 <= side_s1;
		end
	end

	// Hold matrix magnitudes
	always_ff @(posedge clk) begin
		if (en[2]) begin
			rm_o   <= rm_d;
			side_o <= side_s2;
		end
	end

endmodule

@@ rtl/core/obaabb_bounds.sv @@
// Half extents from matrix and box size, then saturated bounds, three stages
module obaabb_bounds (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [2:0]                            en,
	input  logic                                  vld_i,
	input  obaabb_pkg::rm_t                       rm_i,
	input  obaabb_pkg::side_t                     side_i,
	output logic [2:0]                            vld_o,
	output logic [2:0][obaabb_pkg::VW-1:0]        lo_o,
	output logic [2:0][obaabb_pkg::VW-1:0]        hi_o
);
	import obaabb_pkg::*;

	logic [8:0][TW-1:0]  thi_s1;
	logic [8:0][RW-1:0]  tlo_s1;
	logic [2:0][CW-1:0]  centre_s1;
	logic [2:0][EW-1:0]  ext_s2;
	logic [2:0][CW-1:0]  centre_s2;

	// Advance valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= '0;
		end else begin
			if (en[0]) vld_o[0] <= vld_i;
			if (en[1]) vld_o[1] <= vld_o[0];
			if (en[2]) vld_o[2] <= vld_o[1];
		end
	end

	// Split each term into high and low partial products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					thi_s1[3*i+j] <= TW'(side_i.h[j][HW-1:QFRAC]) * TW'(rm_i[3*i+j]);
					tlo_s1[3*i+j] <= RW'(((QFRAC+RW)'(side_i.h[j][QFRAC-1:0])
						* (QFRAC+RW)'(rm_i[3*i+j])) >> QFRAC);
				end
			end
			centre_s1 <= side_i.centre;
		end
	end

	// Sum the terms of each row
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				ext_s2[i] <= EW'(thi_s1[3*i]) + EW'(tlo_s1[3*i])
					+ EW'(thi_s1[3*i+1]) + EW'(tlo_s1[3*i+1])
					+ EW'(thi_s1[3*i+2]) + EW'(tlo_s1[3*i+2]);
			end
			centre_s2 <= centre_s1;
		end
	end

	// Form and saturate the bounds
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				lo_o[i] <= sat32(BW'($signed(centre_s2[i])) - $signed(BW'(ext_s2[i])));
				hi_o[i] <= sat32(BW'($signed(centre_s2[i])) + $signed(BW'(ext_s2[i])));
			end
		end
	end

endmodule

@@ rtl/core/oriented_box_aabb.sv @@
// Top level: axis-aligned bounds of a rotated, scaled and offset box
//
// Input channel: in_valid/in_stall with position, Euler angles and scale.
// Output channel: out_valid/out_stall with min and max per world axis.
// A transfer happens on a rising edge with valid high and stall low.
// Configuration: wr_en/wr_index/wr_data write box size (clamped to 0.01)
// and box offset; write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled; the
// stages form a row of cells (front end, u squared, six Horner cells,
// sine finish, two matrix stages, partial products, row sum, saturating
// bounds), through which each input transfer passes in order.
// When the receiver stalls, the result holds in the output register and
// stages behind it keep filling empty slots; in_stall rises only when
// every stage holds an item.
// Reset clears all stage valids and loads box size 1.0 and offset 0.
module oriented_box_aabb (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [2:0]                    wr_index,
	input  logic [obaabb_pkg::VW-1:0]     wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [obaabb_pkg::VW-1:0]  pos_x,
	input  logic signed [obaabb_pkg::VW-1:0]  pos_y,
	input  logic signed [obaabb_pkg::VW-1:0]  pos_z,
	input  logic [obaabb_pkg::AIW-1:0]    angle_x,
	input  logic [obaabb_pkg::AIW-1:0]    angle_y,
	input  logic [obaabb_pkg::AIW-1:0]    angle_z,
	input  logic signed [obaabb_pkg::VW-1:0]  scale_x,
	input  logic signed [obaabb_pkg::VW-1:0]  scale_y,
	input  logic signed [obaabb_pkg::VW-1:0]  scale_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [obaabb_pkg::VW-1:0]  min_x,
	output logic signed [obaabb_pkg::VW-1:0]  min_y,
	output logic signed [obaabb_pkg::VW-1:0]  min_z,
	output logic signed [obaabb_pkg::VW-1:0]  max_x,
	output logic signed [obaabb_pkg::VW-1:0]  max_y,
	output logic signed [obaabb_pkg::VW-1:0]  max_z
);
	import obaabb_pkg::*;

	logic [SW-1:0]       size_q [3];
	logic signed [VW-1:0] off_q [3];

	logic [NST-1:0]      vld;
	logic [NST-1:0]      rdy;

	logic [AIW-1:0]      ang [3];
	logic signed [VW-1:0] pos [3];
	logic signed [VW-1:0] scl [3];

	lvec_t               lanes_d;
	side_t               side_d;
	lvec_t               lanes_s1;
	side_t               side_s1;
	lvec_t               lanes_s2;
	side_t               side_s2;
	lvec_t               lanes_c [7];
	side_t               side_c [7];
	rm_t                 rm_m;
	side_t               side_m;
	logic [2:0][VW-1:0]  lo_b;
	logic [2:0][VW-1:0]  hi_b;

	assign ang = '{angle_x, angle_y, angle_z};
	assign pos = '{pos_x, pos_y, pos_z};
	assign scl = '{scale_x, scale_y, scale_z};

	// Write configuration registers, clamp box size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				size_q[i] <= SIZE_RESET;
				off_q[i]  <= '0;
			end
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z:
					size_q[wr_index[1:0]] <= (wr_data[SW-1:0] < SIZE_MIN) ? SIZE_MIN
						: wr_data[SW-1:0];
				REG_OFF_X: off_q[0] <= $signed(wr_data);
				REG_OFF_Y: off_q[1] <= $signed(wr_data);
				REG_OFF_Z: off_q[2] <= $signed(wr_data);
				default: ;
			endcase
		end
	end

	// Ready chain: a stage loads when empty or when its successor loads
	always_comb begin
		rdy[NST-1] = !vld[NST-1] || !out_stall;
		for (int k = NST - 2; k >= 0; k--)
			rdy[k] = !vld[k] || rdy[k+1];
	end
	assign in_stall = !rdy[0];

	// Front end: quadrant, fraction, centre and half size
	always_comb begin
		logic [AQW-1:0]     r;
		logic [QFRAC-1:0]   f;
		logic [VW-1:0]      ms;
		logic [SW+VW-1:0]   pr;
		for (int a = 0; a < 3; a++) begin
			r = ang[a][AQW-1:0];
			f = {r, (QFRAC-AQW)'(0)};
			side_d.quad[a] = ang[a][ANGLE_BITS-1:AQW];
			side_d.fz[a]   = (r == '0);
			lanes_d[2*a].p    = '0;
			lanes_d[2*a].u2   = '0;
			lanes_d[2*a].u    = UW'(f);
			lanes_d[2*a+1].p  = '0;
			lanes_d[2*a+1].u2 = '0;
			lanes_d[2*a+1].u  = UW'(QONE) - UW'(f);
			side_d.centre[a] = CW'($signed(CW'(pos[a])) + $signed(CW'(off_q[a])));
			ms = scl[a][VW-1] ? VW'(-scl[a]) : VW'(scl[a]);
			pr = (SW+VW)'(size_q[a]) * (SW+VW)'(ms);
			side_d.h[a] = pr[SW+VW-1:FRAC_BITS+1];
		end
	end

	// Advance front-end valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[1:0] <= '0;
		end else begin
			if (rdy[0]) vld[0] <= in_valid;
			if (rdy[1]) vld[1] <= vld[0];
		end
	end

	// Hold front-end payload
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			lanes_s1 <= lanes_d;
			side_s1  <= side_d;
		end
	end

	// Square u and seed the polynomial
	always_ff @(posedge clk) begin
		logic [2*UW-1:0] sq;
		if (rdy[1]) begin
			for (int l = 0; l < 6; l++) begin
				sq = (2*UW)'(lanes_s1[l].u) * (2*UW)'(lanes_s1[l].u);
				lanes_s2[l].u2 <= UW'(sq >> QFRAC);
				lanes_s2[l].u  <= lanes_s1[l].u;
				lanes_s2[l].p  <= SIN_COEF[NCOEF-1];
			end
			side_s2 <= side_s1;
		end
	end

	assign lanes_c[0] = lanes_s2;
	assign side_c[0]  = side_s2;

	// Horner cells, highest coefficient first
	for (genvar g = 0; g < NCOEF - 1; g++) begin : g_horner
		obaabb_horner_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (rdy[2+g]),
			.coef    (SIN_COEF[NCOEF-2-g]),
			.vld_i   (vld[1+g]),
			.lanes_i (lanes_c[g]),
			.side_i  (side_c[g]),
			.vld_o   (vld[2+g]),
			.lanes_o (lanes_c[g+1]),
			.side_o  (side_c[g+1])
		);
	end

	obaabb_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (rdy[10:8]),
		.vld_i   (vld[7]),
		.lanes_i (lanes_c[NCOEF-1]),
		.side_i  (side_c[NCOEF-1]),
		.vld_o   (vld[10:8]),
		.rm_o    (rm_m),
		.side_o  (side_m)
	);

	obaabb_bounds u_bounds (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (rdy[13:11]),
		.vld_i   (vld[10]),
		.rm_i    (rm_m),
		.side_i  (side_m),
		.vld_o   (vld[13:11]),
		.lo_o    (lo_b),
		.hi_o    (hi_b)
	);

	assign out_valid = vld[NST-1];
	assign min_x = $signed(lo_b[0]);
	assign min_y = $signed(lo_b[1]);
	assign min_z = $signed(lo_b[2]);
	assign max_x = $signed(hi_b[0]);
	assign max_y = $signed(hi_b[1]);
	assign max_z = $signed(hi_b[2]);

	`include "oriented_box_aabb_assert.svh"

	`OBA_ASSERT_IMP(a_empty_out_never_stalls, !out_valid, !in_stall)
	`OBA_ASSERT_IMP(a_x_bounds_ordered, out_valid, min_x <= max_x)
	`OBA_ASSERT_IMP(a_z_bounds_ordered, out_valid, min_z <= max_z)
	`OBA_ASSERT_NXT(a_size_clamped, wr_en && (wr_index == REG_SIZE_X), size_q[0] >= SIZE_MIN)

endmodule

@@ tb/oriented_box_aabb_test.sv @@
// Self-checking testbench for the oriented box bounds block
module oriented_box_aabb_test;
	import obaabb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 30;
	localparam int PHASE_ITEMS    = 155;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;
	localparam logic signed [31:0] ONE_Q16 = 32'sh00010000;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][15:0] ang;
		logic [2:0][31:0] scl;
	} obj_t;

	// Bounds ordered min_x, min_y, min_z, max_x, max_y, max_z
	typedef logic [5:0][31:0] bounds_t;

	typedef struct packed {
		obj_t    obj;
		logic    typed;
		bounds_t bounds;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = '0;
	logic [31:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [15:0] angle_x = '0, angle_y = '0, angle_z = '0;
	logic signed [31:0] scale_x = '0, scale_y = '0, scale_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] min_x, min_y, min_z, max_x, max_y, max_z;

	oriented_box_aabb u_top (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.min_x(min_x), .min_y(min_y), .min_z(min_z),
		.max_x(max_x), .max_y(max_y), .max_z(max_z)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mirror of the box registers
	longint unsigned size_m [3];
	longint offset_m [3];

	bounds_t bounds_q [$];
	int fails = 0;
	bit calm = 1'b0;
	int idle_cnt = 0;

	const longint sin_coef [7] = '{1686629713, -693598668, 85569306, -5026995,
		172272, -3864, 61};

	function automatic longint unsigned amag(longint a);
		return a < 0 ? longint'(-a) : a;
	endfunction

	function automatic longint qprod(longint a, longint b);
		longint unsigned m;
		m = (amag(a) * amag(b)) >> 30;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint quarter_sin(longint u);
		longint u2;
		longint p;
		u2 = qprod(u, u);
		p = sin_coef[6];
		for (int k = 5; k >= 0; k--)
			p = sin_coef[k] + qprod(p, u2);
		p = qprod(p, u);
		if (p < 0) p = 0;
		if (p > (64'sd1 << 30)) p = 64'sd1 << 30;
		return p;
	endfunction

	function automatic void angle_sin_cos(input logic [15:0] a, output longint s,
		output longint c);
		longint f;
		longint s0;
		longint c0;
		f = longint'(a[13:0]) << 16;
		if (f == 0) begin
			s0 = 0;
			c0 = 64'sd1 << 30;
		end else begin
			s0 = quarter_sin(f);
			c0 = quarter_sin((64'sd1 << 30) - f);
		end
		case (a[15:14])
			2'd0: begin s = s0; c = c0; end
			2'd1: begin s = c0; c = -s0; end
			2'd2: begin s = -s0; c = -c0; end
			default: begin s = -c0; c = s0; end
		endcase
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return S32_MAX;
		if (v < -64'sd2147483648) return S32_MIN;
		return v[31:0];
	endfunction

	function automatic bounds_t predict_bounds(obj_t o);
		longint sx, cx, sy, cy, sz, cz, sxsy, cxsy, centre;
		longint unsigned rm [3][3];
		longint unsigned h [3];
		longint unsigned ext;
		bounds_t b;
		angle_sin_cos(o.ang[0], sx, cx);
		angle_sin_cos(o.ang[1], sy, cy);
		angle_sin_cos(o.ang[2], sz, cz);
		sxsy = qprod(sx, sy);
		cxsy = qprod(cx, sy);
		rm[0][0] = amag(qprod(cy, cz));
		rm[0][1] = amag(qprod(cy, sz));
		rm[0][2] = amag(sy);
		rm[1][0] = amag(qprod(sxsy, cz) + qprod(cx, sz));
		rm[1][1] = amag(qprod(cx, cz) - qprod(sxsy, sz));
		rm[1][2] = amag(qprod(sx, cy));
		rm[2][0] = amag(qprod(sx, sz) - qprod(cxsy, cz));
		rm[2][1] = amag(qprod(cxsy, sz) + qprod(sx, cz));
		rm[2][2] = amag(qprod(cx, cy));
		for (int j = 0; j < 3; j++)
			h[j] = (size_m[j] * amag(longint'($signed(o.scl[j])))) >> 17;
		for (int i = 0; i < 3; i++) begin
			centre = longint'($signed(o.pos[i])) + offset_m[i];
			ext = 0;
			for (int j = 0; j < 3; j++)
				ext += (h[j] >> 30) * rm[i][j] + (((h[j] & 64'h3FFFFFFF) * rm[i][j]) >> 30);
			b[i] = clamp32(centre - longint'(ext));
			b[3 + i] = clamp32(centre + longint'(ext));
		end
		return b;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	// Check each output transfer against the oldest expectation
	always @(posedge clk) begin
		bounds_t got;
		bounds_t want;
		string names [6];
		names = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};
		got = {max_z, max_y, max_x, min_z, min_y, min_x};
		if (arst_n && out_valid && !out_stall) begin
			if (bounds_q.size() == 0) begin
				report("unexpected transfer", got[0], '0);
			end else begin
				want = bounds_q.pop_front();
				for (int k = 0; k < 6; k++)
					if (got[k] !== want[k]) report(names[k], got[k], want[k]);
			end
		end
	end

	// Stall the output at random, except during calm stretches
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 35);
	end

	// Count cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= WATCHDOG_LIMIT) begin
				$display("oriented_box_aabb_test NOT OK");
				$finish;
			end
		end
	end

	// Drive one transfer, then idle at random
	task automatic send_obj(obj_t o, logic typed, bounds_t typed_b);
		int gap;
		{pos_z, pos_y, pos_x} <= o.pos;
		{angle_z, angle_y, angle_x} <= o.ang;
		{scale_z, scale_y, scale_x} <= o.scl;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bounds_q.push_back(typed ? typed_b : predict_bounds(o));
		if (!calm && $urandom_range(99) < 22) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bounds_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write a register and update the mirror
	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		case (idx)
			REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z:
				size_m[idx] = (d[30:0] < SIZE_MIN) ? SIZE_MIN : d[30:0];
			REG_OFF_X, REG_OFF_Y, REG_OFF_Z:
				offset_m[idx - REG_OFF_X] = longint'($signed(d));
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_len();
		int pick;
		pick = $urandom_range(99);
		if (pick < 75) return 32'($signed($urandom()) >>> 9);
		if (pick < 90) return $urandom();
		case ($urandom_range(3))
			0: return S32_MAX;
			1: return S32_MIN;
			2: return 32'd0;
			default: return -32'sd1;
		endcase
	endfunction

	function automatic logic [15:0] rand_angle();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60) return 16'($urandom());
		if (pick < 85) return 16'(($urandom_range(3) << 14) + $urandom_range(2) - 1);
		return 16'($urandom_range(64));
	endfunction

	function automatic logic [31:0] rand_scale();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) return 32'($signed($urandom()) >>> 12);
		if (pick < 90) return $urandom();
		case ($urandom_range(3))
			0: return S32_MAX;
			1: return S32_MIN;
			2: return 32'd0;
			default: return -ONE_Q16;
		endcase
	endfunction

	function automatic logic [31:0] rand_size();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) return $urandom_range(1 << 10, 1 << 21);
		if (pick < 85) return $urandom_range(800);
		return $urandom();
	endfunction

	function automatic row_t mk_row(logic [31:0] p, logic [15:0] a0, logic [15:0] a1,
		logic [15:0] a2, logic [31:0] s, logic typed, logic [31:0] lo, logic [31:0] hi);
		row_t r;
		r.obj.pos = {p, p, p};
		r.obj.ang = {a2, a1, a0};
		r.obj.scl = {s, s, s};
		r.typed = typed;
		r.bounds = {hi, hi, hi, lo, lo, lo};
		return r;
	endfunction

	initial begin
		row_t rows [$];
		obj_t o;
		bounds_t none;
		logic [31:0] sz [3];
		logic [31:0] off [3];
		none = '0;
		for (int i = 0; i < 3; i++) begin
			size_m[i] = SIZE_RESET;
			offset_m[i] = 0;
		end

		// Extremes with the reset box, then the quadrant edges of each axis
		rows.push_back(mk_row(0, 0, 0, 0, ONE_Q16, 1, -32'sd32768, 32'sd32768));
		rows.push_back(mk_row(0, 0, 0, 0, -ONE_Q16, 1, -32'sd32768, 32'sd32768));
		rows.push_back(mk_row(S32_MAX, 0, 0, 0, 0, 1, S32_MAX, S32_MAX));
		rows.push_back(mk_row(S32_MIN, 0, 0, 0, 0, 1, S32_MIN, S32_MIN));
		rows.push_back(mk_row(S32_MAX, 0, 0, 0, ONE_Q16, 1, S32_MAX - 32768, S32_MAX));
		rows.push_back(mk_row(S32_MIN, 0, 0, 0, ONE_Q16, 1, S32_MIN, S32_MIN + 32768));
		rows.push_back(mk_row(0, 0, 0, 0, S32_MIN, 1, -32'sd1073741824, 32'sd1073741824));
		rows.push_back(mk_row(0, 0, 0, 0, S32_MAX, 0, 0, 0));
		rows.push_back(mk_row(0, 16384, 0, 0, ONE_Q16, 0, 0, 0));
		rows.push_back(mk_row(0, 0, 16384, 0, ONE_Q16, 0, 0, 0));
		rows.push_back(mk_row(0, 0, 0, 16384, ONE_Q16, 0, 0, 0));
		rows.push_back(mk_row(0, 32768, 32768, 32768, ONE_Q16, 0, 0, 0));
		rows.push_back(mk_row(0, 49152, 49152, 49152, ONE_Q16, 0, 0, 0));
		rows.push_back(mk_row(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, ONE_Q16, 0, 0, 0));
		rows.push_back(mk_row(0, 1, 1, 1, ONE_Q16, 0, 0, 0));
		rows.push_back(mk_row(0, 8192, 8192, 8192, ONE_Q16, 0, 0, 0));
		rows.push_back(mk_row(0, 16383, 16385, 32767, -ONE_Q16, 0, 0, 0));
		rows.push_back(mk_row(S32_MAX, 8192, 24576, 40960, S32_MAX, 0, 0, 0));
		rows.push_back(mk_row(S32_MIN, 16'hAAAA, 16'h5555, 16'h1234, S32_MIN, 0, 0, 0));
		rows.push_back(mk_row(-32'sd1, 16'hFFFF, 0, 16384, -32'sd1, 0, 0, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_obj(rows[i].obj, rows[i].typed, rows[i].bounds);

		// Hold off until the pipeline is empty before the first phase
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			for (int i = 0; i < 3; i++) begin
				sz[i] = rand_size();
				off[i] = rand_len();
			end
			case (ph)
				0: begin
					sz = '{32'd0, 32'd654, 32'd655};
					off = '{S32_MAX, S32_MAX, S32_MAX};
				end
				1: begin
					sz = '{32'hFFFFFFFF, 32'h7FFFFFFF, 32'd656};
					off = '{S32_MIN, S32_MIN, S32_MIN};
				end
				2: off = '{32'd0, 32'd0, 32'd0};
				default: ;
			endcase
			write_reg(REG_SIZE_X, sz[0]);
			write_reg(REG_SIZE_Y, sz[1]);
			write_reg(REG_SIZE_Z, sz[2]);
			write_reg(REG_OFF_X, off[0]);
			write_reg(REG_OFF_Y, off[1]);
			write_reg(REG_OFF_Z, off[2]);
			// Spare indexes must be ignored
			write_reg((ph % 2) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
			wr_en <= 1'b0;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				calm = (ph == 3) && (n >= 20) && (n < 120);
				for (int i = 0; i < 3; i++) begin
					o.pos[i] = rand_len();
					o.ang[i] = rand_angle();
					o.scl[i] = rand_scale();
				end
				send_obj(o, 1'b0, none);
				// Let the pipeline empty once in mid phase
				if (ph == 4 && n == 70) drain();
			end
			calm = 1'b0;
			drain();
		end

		if (fails == 0)
			$display("oriented_box_aabb_test OK");
		else
			$display("oriented_box_aabb_test NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/obaabb_pkg.sv
rtl/core/obaabb_horner_cell.sv
rtl/core/obaabb_matrix.sv
rtl/core/obaabb_bounds.sv
rtl/core/oriented_box_aabb.sv
tb/oriented_box_aabb_test.sv
